/* rtl/urzc_pkg.sv */
// Package for the ultrasonic ranger zone classifier: payload and
// configuration types, register indexes, phase codes and the sensor table.
// No dependencies.
`default_nettype none

package urzc_pkg;

  localparam int unsigned NumSensors = 6;
  localparam int unsigned DefCountWidth = 16;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth = 18;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] RegNearLimit    = 3'd0;
  localparam logic [CfgIndexWidth-1:0] RegZone2Limit   = 3'd1;
  localparam logic [CfgIndexWidth-1:0] RegZone3Limit   = 3'd2;
  localparam logic [CfgIndexWidth-1:0] RegZone4Limit   = 3'd3;
  localparam logic [CfgIndexWidth-1:0] RegTriggerTicks = 3'd4;
  localparam logic [CfgIndexWidth-1:0] RegPrescale     = 3'd5;
  localparam logic [CfgIndexWidth-1:0] RegHoldoffTicks = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [15:0] RstNearLimit    = 16'd700;
  localparam logic [15:0] RstZone2Limit   = 16'd1400;
  localparam logic [15:0] RstZone3Limit   = 16'd2360;
  localparam logic [15:0] RstZone4Limit   = 16'd3200;
  localparam logic [11:0] RstTriggerTicks = 12'd128;
  localparam logic [10:0] RstPrescale     = 11'd64;
  localparam logic [17:0] RstHoldoffTicks = 18'd160000;

  localparam logic [10:0] PrescaleMax = 11'd1024;

  // Zone codes.
  localparam logic [2:0] ZoneNone = 3'd0;
  localparam logic [2:0] Zone1    = 3'd1;
  localparam logic [2:0] Zone2    = 3'd2;
  localparam logic [2:0] Zone3    = 3'd3;
  localparam logic [2:0] Zone4    = 3'd4;
  localparam logic [2:0] Zone5    = 3'd5;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_TRIG = 5'b00010,
    PH_WAIT = 5'b00100,
    PH_MEAS = 5'b01000,
    PH_HOLD = 5'b10000
  } phase_t;

  typedef struct packed {
    logic                  start_req;
    logic [1:0]            direction;
    logic [NumSensors-1:0] echo_levels;
  } in_item_t;

  typedef struct packed {
    logic [NumSensors-1:0] trigger_drive;
    logic                  busy_res;
    logic                  done_res;
    logic [2:0]            zone;
    logic [15:0]           width_count;
  } out_item_t;

  typedef struct packed {
    logic [15:0] near_limit;
    logic [15:0] zone2_limit;
    logic [15:0] zone3_limit;
    logic [15:0] zone4_limit;
    logic [11:0] trigger_ticks;
    logic [10:0] prescale;
    logic [17:0] holdoff_ticks;
  } cfg_t;

  // First sensor measured for each direction; pairs go on to the next one.
  function automatic logic [2:0] first_sensor(input logic [1:0] dir);
    logic [2:0] s;
    case (dir)
      2'd0:    s = 3'd0;
      2'd1:    s = 3'd2;
      2'd2:    s = 3'd3;
      default: s = 3'd5;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/urzc_core.sv */
// Measurement sequencer of the ranger: phase machine, tick and prescale
// counters, width counter and zone grading. Uses urzc_pkg.
`default_nettype none

module urzc_core import urzc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = DefCountWidth
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire in_item_t  item,
  input  wire cfg_t      cfg,
  output out_item_t      result
);

  localparam int unsigned GradeWidth = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] WidthMax = {COUNT_WIDTH{1'b1}};

  phase_t                 phase, phase_next;
  logic [2:0]             sensor_index, sensor_index_next;
  logic [1:0]             direction_held, direction_held_next;
  logic [17:0]            tick_count, tick_count_next;
  logic [9:0]             prescale_count, prescale_count_next;
  logic [COUNT_WIDTH-1:0] echo_width, echo_width_next;
  logic [2:0]             best_zone, best_zone_next;
  logic [2:0]             result_zone, result_zone_next;
  logic                   done;

  logic [7:0]             echo_ext;
  logic                   mybit;
  logic [10:0]            ps;
  logic [18:0]            tick_inc;
  logic [10:0]            pre_inc;
  logic [GradeWidth-1:0]  w_ext;
  logic [GradeWidth-1:0]  w_ext_next;
  logic [2:0]             grade_z;
  logic                   pair;
  logic [7:0]             trig_ext;

  assign echo_ext = {2'b00, item.echo_levels};
  assign mybit    = echo_ext[sensor_index];
  assign ps       = (cfg.prescale == 11'd0) ? 11'd1 :
                    ((cfg.prescale > PrescaleMax) ? PrescaleMax : cfg.prescale);
  assign tick_inc = {1'b0, tick_count} + 19'd1;
  assign pre_inc  = {1'b0, prescale_count} + 11'd1;
  assign w_ext    = GradeWidth'(echo_width);
  assign w_ext_next = GradeWidth'(echo_width_next);
  assign pair     = ~direction_held[0];

  // Limits are tested in zone order, so out-of-order limits still resolve.
  always_comb begin
    if (w_ext < GradeWidth'(cfg.near_limit)) begin
      grade_z = Zone1;
    end else if (w_ext < GradeWidth'(cfg.zone2_limit)) begin
      grade_z = Zone2;
    end else if (w_ext < GradeWidth'(cfg.zone3_limit)) begin
      grade_z = Zone3;
    end else if (w_ext < GradeWidth'(cfg.zone4_limit)) begin
      grade_z = Zone4;
    end else begin
      grade_z = Zone5;
    end
  end

  always_comb begin
    phase_next          = phase;
    sensor_index_next   = sensor_index;
    direction_held_next = direction_held;
    tick_count_next     = tick_count;
    prescale_count_next = prescale_count;
    echo_width_next     = echo_width;
    best_zone_next      = best_zone;
    result_zone_next    = result_zone;
    done                = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (item.start_req) begin
          direction_held_next = item.direction;
          sensor_index_next   = first_sensor(item.direction);
          tick_count_next     = 18'd0;
          phase_next          = PH_TRIG;
        end
      end
      PH_TRIG: begin
        tick_count_next = tick_inc[17:0];
        if (tick_inc[17:0] >= 18'(cfg.trigger_ticks)) begin
          phase_next = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (mybit) begin
          echo_width_next     = '0;
          prescale_count_next = 10'd0;
          phase_next          = PH_MEAS;
        end
      end
      PH_MEAS: begin
        if (mybit) begin
          if (pre_inc >= ps) begin
            prescale_count_next = 10'd0;
            if (echo_width != WidthMax) begin
              echo_width_next = echo_width + COUNT_WIDTH'(1);
            end
          end else begin
            prescale_count_next = pre_inc[9:0];
          end
        end else begin
          tick_count_next = 18'd0;
          phase_next      = PH_HOLD;
        end
      end
      PH_HOLD: begin
        if (tick_inc >= {1'b0, cfg.holdoff_ticks}) begin
          if (pair && (sensor_index == first_sensor(direction_held))) begin
            best_zone_next    = grade_z;
            sensor_index_next = sensor_index + 3'd1;
            tick_count_next   = 18'd0;
            phase_next        = PH_TRIG;
          end else begin
            if (pair && (best_zone < grade_z)) begin
              result_zone_next = best_zone;
            end else begin
              result_zone_next = grade_z;
            end
            done       = 1'b1;
            phase_next = PH_IDLE;
          end
        end else begin
          tick_count_next = tick_inc[17:0];
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      sensor_index   <= 3'd0;
      direction_held <= 2'd0;
      tick_count     <= 18'd0;
      prescale_count <= 10'd0;
      echo_width     <= '0;
      best_zone      <= ZoneNone;
      result_zone    <= ZoneNone;
    end else if (step) begin
      phase          <= phase_next;
      sensor_index   <= sensor_index_next;
      direction_held <= direction_held_next;
      tick_count     <= tick_count_next;
      prescale_count <= prescale_count_next;
      echo_width     <= echo_width_next;
      best_zone      <= best_zone_next;
      result_zone    <= result_zone_next;
    end
  end

  // The result reflects the state after this tick.
  assign trig_ext = (phase_next == PH_TRIG) ? (8'd1 << sensor_index_next) : 8'd0;

  always_comb begin
    result.trigger_drive = trig_ext[NumSensors-1:0];
    result.busy_res      = (phase_next != PH_IDLE);
    result.done_res      = done;
    result.zone          = result_zone_next;
    result.width_count   = w_ext_next[15:0];
  end

endmodule

`default_nettype wire

/* rtl/ultrasonic_ranger_zone_classifier_top.sv */
// Top level of the ultrasonic ranger zone classifier: configuration
// registers, sequencer instance and output register with skid stage.
// Uses urzc_pkg and urzc_core.
`default_nettype none

// Each accepted input request is one base tick: the start request, the
// direction and the six sampled echo levels. Each request yields exactly one
// result: trigger drive, busy, done, last zone and echo width, all taken
// from the sequencer state after that tick.
// The sequencer steps once per accepted request, and its result is registered
// at the edge that accepts the request. With out_ready high the block
// takes one request every cycle; throughput is one tick per cycle.
// When the receiver stalls, the output register holds its result and one
// more result is caught in a skid stage; in_ready then drops until the
// output side drains. Timing in the sequencer counts requests, not cycles.
// Configuration writes (cfg_valid with cfg_index and cfg_data) are always
// taken and should only be issued while no measurement runs. Indexes past
// the last register are ignored.
// Synchronous reset returns the sequencer to idle, loads the register
// defaults, sets zone to none and empties the output and skid stages.
module ultrasonic_ranger_zone_classifier_top import urzc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = DefCountWidth
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire in_item_t                 in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output out_item_t                     out_data,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data
);

  cfg_t      cfg;
  out_item_t core_result;
  out_item_t skid_data;
  logic      skid_valid;
  logic      in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~skid_valid;
  assign in_fire   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_limit    <= RstNearLimit;
      cfg.zone2_limit   <= RstZone2Limit;
      cfg.zone3_limit   <= RstZone3Limit;
      cfg.zone4_limit   <= RstZone4Limit;
      cfg.trigger_ticks <= RstTriggerTicks;
      cfg.prescale      <= RstPrescale;
      cfg.holdoff_ticks <= RstHoldoffTicks;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegNearLimit:    cfg.near_limit    <= cfg_data[15:0];
        RegZone2Limit:   cfg.zone2_limit   <= cfg_data[15:0];
        RegZone3Limit:   cfg.zone3_limit   <= cfg_data[15:0];
        RegZone4Limit:   cfg.zone4_limit   <= cfg_data[15:0];
        RegTriggerTicks: cfg.trigger_ticks <= cfg_data[11:0];
        RegPrescale:     cfg.prescale      <= cfg_data[10:0];
        RegHoldoffTicks: cfg.holdoff_ticks <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  urzc_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (in_fire),
    .item   (in_data),
    .cfg    (cfg),
    .result (core_result)
  );

  // A full skid stage blocks input, so a new result never meets it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_fire) begin
        out_data <= core_result;
      end
    end else if (in_fire) begin
      skid_data <= core_result;
    end
  end

endmodule

`default_nettype wire
